FILE: hw/rtl/hcgt_pkg.sv
// shared constants and the log2 mantissa table for the heavy compression gain tracker
`timescale 1ns / 1ps

package hcgt_pkg;

  localparam int MANT_W = 4;
  localparam int EXPONENT_BITS = 4;

  localparam int PEAK_W  = 17;
  localparam int DCODE_W = 5;
  localparam int LEVEL_W = 15;
  localparam int STEP_W  = 12;
  localparam int GAIN_W  = 17;
  localparam int CODE_W  = 8;
  localparam int WIDE_W  = 18;
  localparam int PROD_W  = 39;
  localparam int XW      = PROD_W - 32;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_DIALOGUE_TARGET = 2'd0,
    REG_PEAK_CEILING    = 2'd1,
    REG_RELEASE_STEP    = 2'd2
  } reg_idx_t;

  localparam logic signed [LEVEL_W-1:0] DIALOGUE_TARGET_RST = -15'sd5120;
  localparam logic signed [LEVEL_W-1:0] PEAK_CEILING_RST    = 15'sd0;
  localparam logic [STEP_W-1:0]         RELEASE_STEP_RST    = 12'd26;

  localparam logic signed [GAIN_W-1:0] GAIN_MIN = -17'sd65536;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 17'sd65535;

  localparam logic signed [PROD_W-1:0] DB_TO_LOG2_Q16 = 39'sd2786635;

  localparam int MANT_MAX = (1 << MANT_W) - 1;
  localparam int TAB_SHIFT = 5 - MANT_W;
  localparam logic signed [XW-1:0] X_LO = XW'(-(1 << (EXPONENT_BITS - 1)));
  localparam logic signed [XW-1:0] X_HI = XW'((1 << (EXPONENT_BITS - 1)) - 1);

  typedef logic [15:0] log2_tab_t [32];

  localparam log2_tab_t LOG2_Q16 = '{
    16'd0,     16'd2910,  16'd5732,  16'd8473,  16'd11137, 16'd13727, 16'd16249, 16'd18705,
    16'd21098, 16'd23433, 16'd25711, 16'd27936, 16'd30110, 16'd32235, 16'd34313, 16'd36346,
    16'd38337, 16'd40286, 16'd42196, 16'd44069, 16'd45905, 16'd47706, 16'd49473, 16'd51208,
    16'd52911, 16'd54585, 16'd56229, 16'd57845, 16'd59434, 16'd60997, 16'd62535, 16'd64048
  };

  function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [WIDE_W-1:0] v);
    logic signed [GAIN_W-1:0] r;
    if (v < WIDE_W'(GAIN_MIN)) begin
      r = GAIN_MIN;
    end else if (v > WIDE_W'(GAIN_MAX)) begin
      r = GAIN_MAX;
    end else begin
      r = v[GAIN_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/heavy_compression_gain_tracker.sv
// heavy compression gain tracker: target gain, release smoothing and compr code encoding
// data path: each input transfer passes through the input, gain, product and
// output registers; the held gain recurrence is a single registered loop
// throughput: one item per cycle unless out_tready stalls the pipeline
// reset: synchronous active-low rst_n clears the pipeline valids, held gain and
// primed flag, and loads the configuration register defaults
`timescale 1ns / 1ps

module heavy_compression_gain_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // peak_level [16:0], dialogue_code [21:17]
  input  logic [hcgt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // gain_code [7:0], held_gain [24:8]
  output logic [hcgt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hcgt_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [hcgt_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [hcgt_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import hcgt_pkg::*;

  // configuration registers
  logic signed [LEVEL_W-1:0] dialogue_target_r;
  logic signed [LEVEL_W-1:0] peak_ceiling_r;
  logic [STEP_W-1:0]         release_step_r;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dialogue_target_r <= DIALOGUE_TARGET_RST;
      peak_ceiling_r    <= PEAK_CEILING_RST;
      release_step_r    <= RELEASE_STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DIALOGUE_TARGET: dialogue_target_r <= cfg_pwdata[LEVEL_W-1:0];
        REG_PEAK_CEILING:    peak_ceiling_r    <= cfg_pwdata[LEVEL_W-1:0];
        REG_RELEASE_STEP:    release_step_r    <= cfg_pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DIALOGUE_TARGET: cfg_prdata = CFG_DATA_W'(dialogue_target_r);
      REG_PEAK_CEILING:    cfg_prdata = CFG_DATA_W'(peak_ceiling_r);
      REG_RELEASE_STEP:    cfg_prdata = CFG_DATA_W'(release_step_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic adv1, adv2, adv3, in_xfer;

  assign adv3      = s2_valid_r && (!out_valid_r || out_tready);
  assign adv2      = s1_valid_r && (!s2_valid_r || adv3);
  assign adv1      = s0_valid_r && (!s1_valid_r || adv2);
  assign in_tready = !s0_valid_r || adv1;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s0_valid_r <= in_tvalid;
      if (!s1_valid_r || adv2) s1_valid_r <= adv1;
      if (!s2_valid_r || adv3) s2_valid_r <= adv2;
      if (!out_valid_r || out_tready) out_valid_r <= adv3;
    end
  end

  // input register
  logic signed [PEAK_W-1:0] peak_r;
  logic [DCODE_W-1:0]       dcode_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      peak_r  <= in_tdata[PEAK_W-1:0];
      dcode_r <= in_tdata[PEAK_W+DCODE_W-1:PEAK_W];
    end
  end

  // gain update
  logic signed [GAIN_W-1:0] gain_level_r, gain_nxt;
  logic                     primed_r;
  logic signed [WIDE_W-1:0] makeup, allowed, target, gain_ext, up;

  always_comb begin
    makeup   = $signed({5'b0, dcode_r, 8'b0}) + WIDE_W'(dialogue_target_r);
    allowed  = WIDE_W'(peak_ceiling_r) - WIDE_W'(peak_r);
    target   = (makeup < allowed) ? makeup : allowed;
    gain_ext = WIDE_W'(gain_level_r);
    up       = gain_ext + $signed({6'b0, release_step_r});
    if (!primed_r || target <= gain_ext) begin
      gain_nxt = sat_gain(target);
    end else begin
      gain_nxt = sat_gain((target < up) ? target : up);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_level_r <= '0;
      primed_r     <= 1'b0;
    end else if (adv1) begin
      gain_level_r <= gain_nxt;
      primed_r     <= 1'b1;
    end
  end

  // db to log2 product
  logic signed [GAIN_W-1:0] s1_gain_r, s2_gain_r;
  logic signed [PROD_W-1:0] s2_prod_r, prod_nxt, gain_wide;

  always_ff @(posedge clk) begin
    if (adv1) s1_gain_r <= gain_nxt;
  end

  assign gain_wide = PROD_W'(s1_gain_r);
  assign prod_nxt  = gain_wide * DB_TO_LOG2_Q16;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_prod_r <= prod_nxt;
      s2_gain_r <= s1_gain_r;
    end
  end

  // code encoding
  logic signed [XW-1:0]       x_raw;
  logic [15:0]                frac;
  logic [MANT_W-1:0]          mant;
  logic [EXPONENT_BITS-1:0]   expo;
  logic [CODE_W-1:0]          code_nxt;

  assign x_raw = s2_prod_r[PROD_W-1:32];
  assign frac  = s2_prod_r[31:16];

  always_comb begin
    mant = '0;
    for (int k = 1; k <= MANT_MAX; k++) begin
      if (frac >= LOG2_Q16[5'(k << TAB_SHIFT)]) mant = MANT_W'(k);
    end
    expo = x_raw[EXPONENT_BITS-1:0];
    if (x_raw < X_LO) begin
      expo = X_LO[EXPONENT_BITS-1:0];
      mant = '0;
    end else if (x_raw > X_HI) begin
      expo = X_HI[EXPONENT_BITS-1:0];
      mant = '1;
    end
    code_nxt = CODE_W'({expo, mant});
  end

  // output register
  logic [CODE_W-1:0]        code_r;
  logic signed [GAIN_W-1:0] out_gain_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      code_r     <= code_nxt;
      out_gain_r <= s2_gain_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - CODE_W - GAIN_W){1'b0}}, out_gain_r, code_r};

  // checks
  a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped");

  a_rise_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (adv1 && primed_r) |-> (WIDE_W'(gain_nxt) <= up || gain_nxt == GAIN_MIN))
    else $error("held gain rose by more than the release step");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && s1_valid_r && s2_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline is full and stalled");

endmodule
